// File: design/cfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg: shared definitions for the framed command parser
// Parse phases, event codes, command codes and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int          DEF_MAX_PAYLOAD = 32;
    localparam int          CMD_MIN_LEN     = 5;
    localparam int          CFG_IDX_W       = 1;
    localparam int          CFG_DATA_W      = 32;

    localparam logic [7:0]  START_BYTE      = 8'hA5;
    localparam logic [7:0]  OPCODE_CMD      = 8'h06;
    localparam logic [7:0]  CMD_SELECT_MODE = 8'h01;
    localparam logic [7:0]  CMD_TUNE_FREQ   = 8'h03;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [31:0] RESET_FREQ_HZ   = 32'd95100000;

    localparam logic [1:0]  MODE_FM         = 2'd0;
    localparam logic [1:0]  MODE_GOES       = 2'd1;
    localparam logic [1:0]  MODE_ADSB       = 2'd2;
    localparam logic [7:0]  ARG_FM          = 8'd0;
    localparam logic [7:0]  ARG_GOES        = 8'd2;
    localparam logic [7:0]  ARG_ADSB        = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ = 1'd1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_OPCODE = 3'd1,
        PH_LENLO  = 3'd2,
        PH_LENHI  = 3'd3,
        PH_PAY    = 3'd4,
        PH_CRCLO  = 3'd5,
        PH_CRCHI  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_OK      = 2'd1,
        EV_CRC_BAD = 2'd2,
        EV_LEN_BAD = 2'd3
    } t_evt;

    typedef struct packed {
        t_evt evt;
        logic nonzero;
        logic magic;
        logic cmd_go;
    } t_parse_res;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: design/cfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_parser: frame synchronizer and CRC checker
// Hunts for the start byte, collects opcode, length, payload and CRC, and
// reports one parse result per accepted byte.
// ----------------------------------------------------------------------------
module cfp_parser #(
    parameter int MAX_PAYLOAD = cfp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output cfp_pkg::t_parse_res  o_res,
    output logic                 o_rd_en,
    output logic [7:0]           o_cmd,
    output logic [31:0]          o_arg
);

    localparam int          FILL_W  = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    cfp_pkg::t_phase   r_phase, n_phase;
    logic [7:0]        r_opcode, n_opcode;
    logic [15:0]       r_len, n_len;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic [7:0]        r_cmd_bytes [cfp_pkg::CMD_MIN_LEN];

    logic [16:0] fill_inc;
    logic [15:0] crc_nx;
    logic [15:0] len_full;
    logic        crc_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cfp_pkg::PH_HUNT;
            r_opcode <= '0;
            r_len    <= '0;
            r_fill   <= '0;
            r_crc    <= cfp_pkg::CRC_INIT;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_fill   <= n_fill;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == cfp_pkg::PH_PAY &&
            r_fill < FILL_W'(cfp_pkg::CMD_MIN_LEN)) begin
            r_cmd_bytes[r_fill[2:0]] <= i_byte;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_len       = r_len;
        n_fill      = r_fill;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        fill_inc    = 17'(r_fill) + 17'd1;
        crc_nx      = cfp_pkg::crc16_byte(r_crc, i_byte);
        len_full    = {i_byte, r_len[7:0]};
        crc_ok      = ({i_byte, r_crc_lo} == r_crc);
        o_res       = '0;
        o_res.evt   = cfp_pkg::EV_NONE;
        o_res.nonzero = (i_byte != 8'h00);
        o_res.magic   = (i_byte == cfp_pkg::START_BYTE);
        o_rd_en     = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                cfp_pkg::PH_OPCODE: begin
                    n_opcode = i_byte;
                    n_crc    = crc_nx;
                    n_phase  = cfp_pkg::PH_LENLO;
                end
                cfp_pkg::PH_LENLO: begin
                    n_len   = {8'h00, i_byte};
                    n_crc   = crc_nx;
                    n_phase = cfp_pkg::PH_LENHI;
                end
                cfp_pkg::PH_LENHI: begin
                    n_len  = len_full;
                    n_crc  = crc_nx;
                    n_fill = '0;
                    if (len_full == 16'h0000) begin
                        n_phase = cfp_pkg::PH_CRCLO;
                    end else if ({1'b0, len_full} > MAX_LEN) begin
                        o_res.evt = cfp_pkg::EV_LEN_BAD;
                        n_phase   = cfp_pkg::PH_HUNT;
                    end else begin
                        n_phase = cfp_pkg::PH_PAY;
                    end
                end
                cfp_pkg::PH_PAY: begin
                    n_crc  = crc_nx;
                    n_fill = FILL_W'(fill_inc);
                    if (fill_inc >= {1'b0, r_len}) begin
                        n_phase = cfp_pkg::PH_CRCLO;
                    end
                end
                cfp_pkg::PH_CRCLO: begin
                    n_crc_lo = i_byte;
                    n_phase  = cfp_pkg::PH_CRCHI;
                end
                cfp_pkg::PH_CRCHI: begin
                    if (crc_ok) begin
                        o_res.evt    = cfp_pkg::EV_OK;
                        o_res.cmd_go = (r_opcode == cfp_pkg::OPCODE_CMD) &&
                                       (r_len >= 16'(cfp_pkg::CMD_MIN_LEN));
                        o_rd_en      = o_res.cmd_go;
                    end else begin
                        o_res.evt = cfp_pkg::EV_CRC_BAD;
                    end
                    n_phase = cfp_pkg::PH_HUNT;
                end
                default: begin
                    if (i_byte == cfp_pkg::START_BYTE) begin
                        n_crc   = cfp_pkg::CRC_INIT;
                        n_phase = cfp_pkg::PH_OPCODE;
                    end else begin
                        n_phase = cfp_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    assign o_cmd = r_cmd_bytes[0];
    assign o_arg = {r_cmd_bytes[4], r_cmd_bytes[3], r_cmd_bytes[2], r_cmd_bytes[1]};

endmodule

// File: design/command_frame_parser_crc16.sv
`timescale 1ns / 1ps
// Each accepted byte is registered in the first stage and moves on to the output
// stage when that stage is empty or its result is being taken.
// Throughput: one byte per cycle; the input stalls only while both stages hold a
// request and the receiver is not ready. The repeat table is read when the CRC high
// byte is accepted and, if new, written as the request enters the output stage.
// Reset: synchronous; the table's valid bits clear at once, with no clearing pass.
// ----------------------------------------------------------------------------
// command_frame_parser_crc16: framed command parser with CRC-16
// Parses framed commands from a byte stream, filters repeated commands with a
// 256-entry argument table and keeps mode, frequency and frame statistics.
// ----------------------------------------------------------------------------
module command_frame_parser_crc16 #(
    parameter int MAX_PAYLOAD = cfp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // rx_byte[7:0]
    input  logic [7:0]                     s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // frame_event[1:0], app_mode[3:2], fm_freq_hz[35:4], retune[36],
    // recent_cmd[44:37], recent_arg[76:45], frames_ok[108:77],
    // frames_crc_bad[140:109], frames_len_bad[172:141], bytes_seen[204:173],
    // nonzero_bytes[236:205], magic_bytes[268:237], zero fill[271:269]
    output logic [271:0]                   m_axis_tdata
);

    logic                accept;
    logic                xfer;
    cfp_pkg::t_parse_res parse_res;
    logic                rd_en;
    logic [7:0]          cmd;
    logic [31:0]         arg;

    logic                r_s1_valid;
    cfp_pkg::t_parse_res r_s1;
    logic                r_out_valid;
    cfp_pkg::t_evt       r_evt;
    logic                r_retune;
    logic [1:0]          r_mode, n_mode;
    logic [31:0]         r_freq, n_freq;
    logic [7:0]          r_recent_cmd;
    logic [31:0]         r_recent_arg;
    logic [31:0]         r_cnt_ok, r_cnt_crc, r_cnt_len, r_cnt_bytes, r_cnt_nz, r_cnt_magic;

    logic [31:0]         r_arg_mem [256];
    logic [255:0]        r_seen;
    logic [31:0]         r_rd_arg;
    logic                r_rd_seen;

    logic                is_repeat;
    logic                tbl_we;
    logic                n_retune;
    logic [1:0]          tgt_mode;
    logic                tgt_ok;

    cfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_res    (parse_res),
        .o_rd_en  (rd_en),
        .o_cmd    (cmd),
        .o_arg    (arg)
    );

    assign xfer          = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || xfer;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_arg  <= r_arg_mem[cmd];
            r_rd_seen <= r_seen[cmd];
        end
        if (tbl_we) begin
            r_arg_mem[cmd] <= arg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (tbl_we) begin
            r_seen[cmd] <= 1'b1;
        end
    end

    always_comb begin
        tgt_ok   = 1'b1;
        tgt_mode = cfp_pkg::MODE_FM;
        unique case (arg[7:0])
            cfp_pkg::ARG_FM:   tgt_mode = cfp_pkg::MODE_FM;
            cfp_pkg::ARG_GOES: tgt_mode = cfp_pkg::MODE_GOES;
            cfp_pkg::ARG_ADSB: tgt_mode = cfp_pkg::MODE_ADSB;
            default:           tgt_ok   = 1'b0;
        endcase
    end

    always_comb begin
        is_repeat = r_rd_seen && (r_rd_arg == arg);
        tbl_we    = xfer && r_s1.cmd_go && !is_repeat;
        n_mode    = r_mode;
        n_freq    = r_freq;
        n_retune  = 1'b0;
        if (tbl_we) begin
            if (cmd == cfp_pkg::CMD_SELECT_MODE) begin
                if (tgt_ok && tgt_mode != r_mode) begin
                    n_mode   = tgt_mode;
                    n_retune = 1'b1;
                end
            end else if (cmd == cfp_pkg::CMD_TUNE_FREQ) begin
                if (arg != 32'h0000_0000) begin
                    n_freq   = arg;
                    n_retune = (r_mode == cfp_pkg::MODE_FM);
                end
            end
        end
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfp_pkg::CFG_START_MODE: begin
                    n_mode = (i_cfg_data[1:0] == 2'd3) ? cfp_pkg::MODE_ADSB
                                                       : i_cfg_data[1:0];
                end
                cfp_pkg::CFG_START_FREQ: begin
                    n_freq = i_cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= cfp_pkg::MODE_FM;
            r_freq       <= cfp_pkg::RESET_FREQ_HZ;
            r_recent_cmd <= '0;
            r_recent_arg <= '0;
            r_cnt_ok     <= '0;
            r_cnt_crc    <= '0;
            r_cnt_len    <= '0;
            r_cnt_bytes  <= '0;
            r_cnt_nz     <= '0;
            r_cnt_magic  <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (xfer) begin
                r_s1_valid <= 1'b0;
            end
            if (xfer) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_mode <= n_mode;
            r_freq <= n_freq;
            if (xfer) begin
                r_cnt_bytes <= r_cnt_bytes + 32'd1;
                if (r_s1.nonzero) begin
                    r_cnt_nz <= r_cnt_nz + 32'd1;
                end
                if (r_s1.magic) begin
                    r_cnt_magic <= r_cnt_magic + 32'd1;
                end
                if (r_s1.evt == cfp_pkg::EV_OK) begin
                    r_cnt_ok <= r_cnt_ok + 32'd1;
                end
                if (r_s1.evt == cfp_pkg::EV_CRC_BAD) begin
                    r_cnt_crc <= r_cnt_crc + 32'd1;
                end
                if (r_s1.evt == cfp_pkg::EV_LEN_BAD) begin
                    r_cnt_len <= r_cnt_len + 32'd1;
                end
                if (r_s1.cmd_go) begin
                    r_recent_cmd <= cmd;
                    r_recent_arg <= arg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= parse_res;
        end
        if (xfer) begin
            r_evt    <= r_s1.evt;
            r_retune <= n_retune;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_cnt_magic, r_cnt_nz, r_cnt_bytes, r_cnt_len,
                            r_cnt_crc, r_cnt_ok, r_recent_arg, r_recent_cmd, r_retune,
                            r_freq, r_mode, r_evt};

    a_rd_wr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !tbl_we)
        else $error("repeat table read and write in the same cycle");

    a_rd_feeds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_s1_valid && r_s1.cmd_go))
        else $error("table read not followed by a pending command");

    a_retune_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_retune) |-> (r_evt == cfp_pkg::EV_OK))
        else $error("retune without an accepted frame");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the pipeline is full");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3)
        else $error("mode holds an unused code");

endmodule
